/* rtl/bspu_pkg.sv */
// ----------------------------------------------------------------------------
// Bit stream packer package
// Shared types, codes and helpers for the bit stream packer and unpacker.
// ----------------------------------------------------------------------------
package bspu_pkg;

  // Field and position widths of the item and result transactions.
  localparam int unsigned MAX_FIELD_BITS = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned POS_W          = 14;
  localparam int unsigned LIM_W          = 11;

  // A field at any bit offset fits in a window one byte wider than the field.
  localparam int unsigned WIN_W     = MAX_FIELD_BITS + 8;
  localparam int unsigned WIN_BYTES = WIN_W / 8;
  localparam int unsigned KW        = $clog2(WIN_BYTES);

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_SEEK    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE         = 2'd0,
    STAT_RANGE        = 2'd1,
    STAT_SEEK_IGNORED = 2'd2
  } status_e;

  typedef enum logic {
    CFG_READ_LIMIT  = 1'b0,
    CFG_WRITE_LIMIT = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_ACCESS,
    BS_MERGE,
    BS_FINISH,
    BS_DONE
  } back_state_e;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    func_e              func;
    logic [CNT_W-1:0]   cnt;
    logic               sgn;
    logic [DATA_W-1:0]  pattern;
    logic [POS_W-1:0]   seek_pos;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    status_e            status;
    logic               error_sticky;
    logic [POS_W-1:0]   cursor;
  } res_t;

  // Mask of the low cnt bits; cnt is already limited to MAX_FIELD_BITS.
  function automatic logic [DATA_W-1:0] field_mask(input logic [CNT_W-1:0] cnt);
    logic [DATA_W:0] one_hot;
    one_hot = (DATA_W + 1)'(1) << cnt;
    return DATA_W'(one_hot - (DATA_W + 1)'(1));
  endfunction

endpackage

/* rtl/bspu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bspu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bspu_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module bspu_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  logic [DW-1:0] data_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = data_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/bspu_front.sv */
// ----------------------------------------------------------------------------
// Front part
// Accepts item transactions, limits the bit count, builds the bit pattern to
// be packed and queues the classified command for the back part.
// ----------------------------------------------------------------------------
module bspu_front import bspu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [CNT_W-1:0]         bit_count_i,
  input  logic                     signed_mode_i,
  input  logic [POS_W-1:0]         seek_position_i,
  input  logic                     hold_i,
  input  logic                     pop_i,
  output cmd_t                     cmd_o,
  output logic                     cmd_valid_o
);

  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] raw;
  logic              neg;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] pattern;
  cmd_t              cmd;
  logic              full;
  logic              empty;
  logic              push;

  // Saturate the count and build the LSB-first bit pattern of the field.
  // In signed mode the sign bit goes first and the magnitude follows.
  always_comb begin
    cnt     = (bit_count_i > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : bit_count_i;
    raw     = value_i;
    neg     = raw[DATA_W-1];
    mag     = neg ? (DATA_W'(0) - raw) : raw;
    pattern = signed_mode_i ? {mag[DATA_W-2:0], neg} : raw;
    pattern = pattern & field_mask(cnt);
  end

  always_comb begin
    cmd.func     = func_e'(func_i);
    cmd.cnt      = cnt;
    cmd.sgn      = signed_mode_i;
    cmd.pattern  = pattern;
    cmd.seek_pos = seek_position_i;
  end

  // Items wait while the store is being cleared or the queue is full.
  assign in_ready_o = !full && !hold_i;
  assign push       = in_valid_i && in_ready_o;

  bspu_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (full),
    .pop_i   (pop_i),
    .data_o  (cmd_o),
    .empty_o (empty)
  );

  assign cmd_valid_o = !empty;

endmodule

/* rtl/bspu_back.sv */
// ----------------------------------------------------------------------------
// Back part
// Holds the cursor, the error flag and the byte store. Checks each command
// against the limits and moves a field one byte per cycle through the store.
// ----------------------------------------------------------------------------
module bspu_back import bspu_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] read_limit_i,
  input  logic [LIM_W-1:0] write_limit_i,
  input  cmd_t             cmd_i,
  input  logic             cmd_valid_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             out_o
);

  localparam int unsigned AW      = $clog2(STORE_BYTES);
  localparam int unsigned LIM_MAX = (1 << LIM_W) - 1;
  localparam int unsigned LIM_CAP = (STORE_BYTES > LIM_MAX) ? LIM_MAX : STORE_BYTES;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  back_state_e state_q, state_d;

  logic [POS_W-1:0]               cursor_q;
  logic                           err_q;
  logic [AW-1:0]                  addr_q;
  logic [AW-1:0]                  wr_addr_q;
  logic                           is_write_q;
  logic                           sgn_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [2:0]                     off_q;
  logic [KW-1:0]                  nb_q;
  logic [KW-1:0]                  k_q;
  logic [WIN_BYTES-1:0][7:0]      win_q;
  logic [WIN_BYTES-1:0][7:0]      wmask_q;
  logic [WIN_BYTES-1:0][7:0]      acc_q;
  logic [DATA_W-1:0]              res_value_q;
  status_e                        res_status_q;
  logic                           out_valid_q;
  res_t                           out_q;

  logic [LIM_W-1:0] rd_lim_bytes;
  logic [LIM_W-1:0] wr_lim_bytes;
  logic [POS_W-1:0] rd_lim_bits;
  logic [POS_W-1:0] wr_lim_bits;
  logic [POS_W:0]   field_end;
  logic             over;
  logic             is_field;
  logic             start_access;
  logic             seek_bad;
  logic [6:0]       span;
  logic [KW-1:0]    nb;
  logic [WIN_W-1:0] win_data;
  logic [WIN_W-1:0] win_mask;
  logic             last;
  logic             out_free;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [7:0]       merged;

  logic [WIN_W-1:0]  acc_flat;
  logic [DATA_W-1:0] field_bits;
  logic [DATA_W-1:0] field_mag;
  logic [DATA_W-1:0] read_value;

  // Limits in bits, clamped to the size of the store.
  always_comb begin
    rd_lim_bytes = (32'(read_limit_i) > LIM_CAP) ? LIM_W'(LIM_CAP) : read_limit_i;
    wr_lim_bytes = (32'(write_limit_i) > LIM_CAP) ? LIM_W'(LIM_CAP) : write_limit_i;
    rd_lim_bits  = {rd_lim_bytes, 3'b000};
    wr_lim_bits  = {wr_lim_bytes, 3'b000};
  end

  // Classify the command at the head of the queue against the cursor.
  always_comb begin
    field_end    = {1'b0, cursor_q} + (POS_W + 1)'(cmd_i.cnt);
    over         = (cmd_i.func == FUNC_WRITE) ? (field_end > {1'b0, wr_lim_bits})
                                              : (field_end > {1'b0, rd_lim_bits});
    is_field     = ((cmd_i.func == FUNC_WRITE) || (cmd_i.func == FUNC_READ)) &&
                   (cmd_i.cnt != '0);
    start_access = is_field && !over;
    seek_bad     = cmd_i.seek_pos > rd_lim_bits;
    span         = 7'(cursor_q[2:0]) + 7'(cmd_i.cnt) + 7'd7;
    nb           = KW'(span >> 3);
    win_data     = WIN_W'(cmd_i.pattern) << cursor_q[2:0];
    win_mask     = WIN_W'(field_mask(cmd_i.cnt)) << cursor_q[2:0];
  end

  assign last     = (k_q == (nb_q - KW'(1)));
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_CLEAR: begin
        if (addr_q == LAST_ADDR) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (cmd_valid_i) begin
          state_d = start_access ? BS_ACCESS : BS_DONE;
        end
      end
      BS_ACCESS: begin
        state_d = BS_MERGE;
      end
      BS_MERGE: begin
        if (last) begin
          state_d = is_write_q ? BS_DONE : BS_FINISH;
        end
      end
      BS_FINISH: begin
        state_d = BS_DONE;
      end
      BS_DONE: begin
        if (out_free) begin
          state_d = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  // Control outputs and store port drive.
  always_comb begin
    pop_o      = (state_q == BS_IDLE) && cmd_valid_i;
    clearing_o = (state_q == BS_CLEAR);
    merged     = (ram_rdata & ~wmask_q[k_q]) | (win_q[k_q] & wmask_q[k_q]);
    ram_we     = (state_q == BS_CLEAR) || ((state_q == BS_MERGE) && is_write_q);
    ram_waddr  = (state_q == BS_CLEAR) ? addr_q : wr_addr_q;
    ram_wdata  = (state_q == BS_CLEAR) ? 8'h00 : merged;
  end

  // Unpack the gathered bytes and decode sign and magnitude.
  always_comb begin
    acc_flat   = acc_q;
    field_bits = DATA_W'(acc_flat >> off_q) & field_mask(cnt_q);
    field_mag  = field_bits >> 1;
    if (sgn_q) begin
      read_value = field_bits[0] ? (DATA_W'(0) - field_mag) : field_mag;
    end else begin
      read_value = field_bits;
    end
  end

  // Control registers: state, cursor, error flag, store address, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_CLEAR;
      cursor_q    <= '0;
      err_q       <= 1'b0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BS_CLEAR: begin
          addr_q <= addr_q + AW'(1);
        end
        BS_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.func)
              FUNC_WRITE, FUNC_READ: begin
                if (is_field) begin
                  if (over) begin
                    err_q <= 1'b1;
                  end else begin
                    cursor_q <= field_end[POS_W-1:0];
                    addr_q   <= AW'(cursor_q[POS_W-1:3]);
                  end
                end
              end
              FUNC_SEEK: begin
                if (!seek_bad) begin
                  cursor_q <= cmd_i.seek_pos;
                end
              end
              FUNC_RESTART: begin
                cursor_q <= '0;
                err_q    <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        BS_ACCESS: begin
          addr_q <= addr_q + AW'(1);
        end
        BS_MERGE: begin
          if (!last) begin
            addr_q <= addr_q + AW'(1);
          end
        end
        default: begin
        end
      endcase
      if ((state_q == BS_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i) begin
          is_write_q   <= (cmd_i.func == FUNC_WRITE);
          sgn_q        <= cmd_i.sgn;
          cnt_q        <= cmd_i.cnt;
          off_q        <= cursor_q[2:0];
          nb_q         <= nb;
          win_q        <= win_data;
          wmask_q      <= win_mask;
          acc_q        <= '0;
          res_value_q  <= '0;
          if (is_field && over) begin
            res_status_q <= STAT_RANGE;
          end else if ((cmd_i.func == FUNC_SEEK) && seek_bad) begin
            res_status_q <= STAT_SEEK_IGNORED;
          end else begin
            res_status_q <= STAT_DONE;
          end
        end
      end
      BS_ACCESS: begin
        wr_addr_q <= addr_q;
        k_q       <= '0;
      end
      BS_MERGE: begin
        acc_q[k_q] <= ram_rdata;
        if (!last) begin
          wr_addr_q <= addr_q;
          k_q       <= k_q + KW'(1);
        end
      end
      BS_FINISH: begin
        res_value_q <= read_value;
      end
      BS_DONE: begin
        if (out_free) begin
          out_q.read_value   <= res_value_q;
          out_q.status       <= res_status_q;
          out_q.error_sticky <= err_q;
          out_q.cursor       <= cursor_q;
        end
      end
      default: begin
      end
    endcase
  end

  bspu_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The byte counter never runs past the bytes that the field spans.
  a_merge_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_MERGE) |-> (k_q < nb_q))
    else $error("byte counter outside field span");

  // Only a write transaction or the clearing pass modifies the store.
  a_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != BS_CLEAR)) |-> is_write_q)
    else $error("store written during a read transaction");

  // A popped command either starts a store access or reports at once.
  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> ((state_q == BS_ACCESS) || (state_q == BS_DONE)))
    else $error("unexpected state after command pop");

  // A field access always spans between one and the window's bytes.
  a_span_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_ACCESS) |-> ((nb_q != '0) && (nb_q <= KW'(WIN_BYTES))))
    else $error("field span out of range");

endmodule

/* rtl/bit_stream_packer_unpacker.sv */
// ----------------------------------------------------------------------------
// Bit stream packer and unpacker
// LSB-first bit fields packed into and unpacked from a byte store at a bit
// cursor, with seek, restart and a sticky range error.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   func, value, bit_count,
//                                                  signed_mode, seek_position
//   out      output     out_valid_o / out_ready_i read_value, status,
//                                                  error_sticky, cursor
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A field of n store bytes (one to five) passes ACCESS, a MERGE per byte
// (one store byte per cycle through the single read and write port) and,
// for a read, FINISH; seek, restart and rejected fields go straight to DONE.
// The front part queues items, so one is accepted while another is at work.
// After reset a clearing pass zeroes every byte of the store; no item
// transaction is accepted during it, configuration writes are.
// A stalled output holds its result; the back part then waits in its last
// state until the output register is free.
// ----------------------------------------------------------------------------
module bit_stream_packer_unpacker import bspu_pkg::*; #(
  parameter int unsigned STORE_BYTES = 1024,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [CNT_W-1:0]         bit_count_i,
  input  logic                     signed_mode_i,
  input  logic [POS_W-1:0]         seek_position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [1:0]               status_o,
  output logic                     error_sticky_o,
  output logic [POS_W-1:0]         cursor_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [LIM_W-1:0]         cfg_data_i
);

  logic [LIM_W-1:0] read_limit_q;
  logic [LIM_W-1:0] write_limit_q;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             pop;
  logic             clearing;
  res_t             res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_limit_q  <= '0;
      write_limit_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_READ_LIMIT:  read_limit_q  <= cfg_data_i;
        CFG_WRITE_LIMIT: write_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bspu_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .value_i         (value_i),
    .bit_count_i     (bit_count_i),
    .signed_mode_i   (signed_mode_i),
    .seek_position_i (seek_position_i),
    .hold_i          (clearing),
    .pop_i           (pop),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid)
  );

  bspu_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .read_limit_i  (read_limit_q),
    .write_limit_i (write_limit_q),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_valid),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (res)
  );

  // Result transaction fields.
  assign read_value_o   = res.read_value;
  assign status_o       = res.status;
  assign error_sticky_o = res.error_sticky;
  assign cursor_o       = res.cursor;

endmodule

/* verif/bit_stream_packer_unpacker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit stream packer and unpacker testbench
// Drives write, read, seek and restart transactions into the block and checks
// every result against a shadow bit store kept in the bench. The run has
// directed field extremes, a shrunken limit case and back pressure, then
// round trips with random content over several limit settings.
// ----------------------------------------------------------------------------
module bit_stream_packer_unpacker_tb;
  import bspu_pkg::*;

  localparam int unsigned STORE_BYTES = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One input transaction as the bench builds it.
  typedef struct packed {
    func_e             func;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  cnt;
    logic              sgn;
    logic [POS_W-1:0]  seek;
  } stream_op_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               func_i;
  logic signed [DATA_W-1:0] value_i;
  logic [CNT_W-1:0]         bit_count_i;
  logic                     signed_mode_i;
  logic [POS_W-1:0]         seek_position_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [1:0]               status_o;
  logic                     error_sticky_o;
  logic [POS_W-1:0]         cursor_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic                     cfg_index_i;
  logic [LIM_W-1:0]         cfg_data_i;

  // Shadow copy of the block state.
  logic [7:0]       shadow_store [STORE_BYTES];
  int unsigned      shadow_cursor;
  logic             shadow_err;
  logic [LIM_W-1:0] shadow_rd_lim;
  logic [LIM_W-1:0] shadow_wr_lim;

  res_t stream_results_q [$];

  // Knobs for the idling of both sides.
  bit          sender_idle;
  bit          receiver_idle;
  int unsigned hold_cycles;
  int unsigned stall_left;

  // Run statistics.
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned range_fails;
  int unsigned seeks_ignored;
  int unsigned limit_settings;
  int unsigned func_count [4];

  bit_stream_packer_unpacker i_dut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending.", cycle_count,
               stream_results_q.size());
      $display("FAIL bit_stream_packer_unpacker");
      $finish;
    end
  end

  // Receiver: random stall bursts plus a long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Prints one line per mismatch and counts all of them.
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result %0d, %s is 0x%0h, expected 0x%0h", $time, results_seen,
             field, got, want);
    mismatches++;
  endtask

  // Each result transaction is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stream_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", read_value_o, '0);
      end else begin
        want = stream_results_q.pop_front();
        if (read_value_o !== want.read_value) begin
          report_mismatch("read_value", read_value_o, want.read_value);
        end
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (error_sticky_o !== want.error_sticky) begin
          report_mismatch("error_sticky", 32'(error_sticky_o), 32'(want.error_sticky));
        end
        if (cursor_o !== want.cursor) begin
          report_mismatch("cursor", 32'(cursor_o), 32'(want.cursor));
        end
        results_seen++;
      end
    end
  end

  // A limit register above the store size acts as the store size.
  function automatic int unsigned limit_bits(input logic [LIM_W-1:0] lim);
    return ((lim > LIM_W'(STORE_BYTES)) ? STORE_BYTES : int'(lim)) * 8;
  endfunction

  // Applies one transaction to the shadow store and queues its result.
  function automatic void apply_stream_op(input stream_op_t op);
    res_t              r;
    int unsigned       cnt;
    int unsigned       pos;
    logic [DATA_W-1:0] field;
    logic [DATA_W-1:0] mag;
    logic              neg;
    r.read_value = '0;
    r.status     = STAT_DONE;
    cnt   = (op.cnt > CNT_W'(MAX_FIELD_BITS)) ? MAX_FIELD_BITS : int'(op.cnt);
    field = '0;
    func_count[op.func]++;
    case (op.func)
      FUNC_WRITE: begin
        if (cnt != 0 && shadow_cursor + cnt > limit_bits(shadow_wr_lim)) begin
          shadow_err = 1'b1;
          r.status   = STAT_RANGE;
        end else if (cnt != 0) begin
          // Signed fields put the sign first and the magnitude after it.
          if (op.sgn) begin
            neg   = op.value[31];
            mag   = neg ? (32'd0 - op.value) : op.value;
            field = {mag[30:0], neg};
          end else begin
            field = op.value;
          end
          for (int i = 0; i < cnt; i++) begin
            pos = shadow_cursor + i;
            shadow_store[pos / 8][pos % 8] = field[i];
          end
          shadow_cursor += cnt;
        end
      end
      FUNC_READ: begin
        if (cnt != 0 && shadow_cursor + cnt > limit_bits(shadow_rd_lim)) begin
          shadow_err = 1'b1;
          r.status   = STAT_RANGE;
        end else if (cnt != 0) begin
          for (int i = 0; i < cnt; i++) begin
            pos      = shadow_cursor + i;
            field[i] = shadow_store[pos / 8][pos % 8];
          end
          if (op.sgn) begin
            mag          = field >> 1;
            r.read_value = field[0] ? (32'd0 - mag) : mag;
          end else begin
            r.read_value = field;
          end
          shadow_cursor += cnt;
        end
      end
      FUNC_SEEK: begin
        if (op.seek > limit_bits(shadow_rd_lim)) begin
          r.status = STAT_SEEK_IGNORED;
        end else begin
          shadow_cursor = op.seek;
        end
      end
      default: begin
        shadow_cursor = 0;
        shadow_err    = 1'b0;
      end
    endcase
    if (r.status == STAT_RANGE) range_fails++;
    if (r.status == STAT_SEEK_IGNORED) seeks_ignored++;
    r.error_sticky = shadow_err;
    r.cursor       = POS_W'(shadow_cursor);
    stream_results_q.push_back(r);
  endfunction

  function automatic stream_op_t mk_op(input func_e f, input logic [31:0] v,
                                       input logic [5:0] c, input logic s,
                                       input logic [13:0] p);
    stream_op_t op;
    op.func  = f;
    op.value = v;
    op.cnt   = c;
    op.sgn   = s;
    op.seek  = p;
    return op;
  endfunction

  // Offers one transaction and waits until it is taken. Valid stays high so
  // that the next transaction can follow on the very next edge.
  task automatic send_op(input stream_op_t op);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= op.func;
    value_i         <= op.value;
    bit_count_i     <= op.cnt;
    signed_mode_i   <= op.sgn;
    seek_position_i <= op.seek;
    do @(posedge clk_i); while (!in_ready_o);
    apply_stream_op(op);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain_stream();
    in_valid_i <= 1'b0;
    while (stream_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes both limit registers back to back; only called while idle.
  task automatic set_limits(input logic [LIM_W-1:0] rd, input logic [LIM_W-1:0] wr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_READ_LIMIT;
    cfg_data_i  <= rd;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_rd_lim = rd;
    cfg_index_i <= CFG_WRITE_LIMIT;
    cfg_data_i  <= wr;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_wr_lim = wr;
    cfg_valid_i <= 1'b0;
    limit_settings++;
  endtask

  // Values lean toward the extremes now and then.
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal widths, sometimes zero or above the field maximum.
  function automatic logic [5:0] random_count();
    case ($urandom_range(0, 11))
      0:       return 6'd0;
      1:       return 6'($urandom_range(33, 63));
      2:       return 6'd32;
      default: return 6'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic stream_op_t random_noise_op();
    logic [13:0] pos;
    if ($urandom_range(0, 2) == 0) pos = 14'($urandom());
    else pos = 14'($urandom_range(0, limit_bits(shadow_rd_lim)));
    return mk_op(func_e'(2'($urandom())), random_value(), random_count(),
                 1'($urandom_range(0, 1)), pos);
  endfunction

  // Writes a run of fields, seeks back and reads them with the same layout.
  task automatic run_round_trip();
    int unsigned span;
    int unsigned start;
    int unsigned n;
    logic [5:0]  cnt_list [6];
    logic        sgn_list [6];
    span = limit_bits(shadow_rd_lim);
    if (limit_bits(shadow_wr_lim) < span) span = limit_bits(shadow_wr_lim);
    if ($urandom_range(0, 9) != 0 && span > 64) start = $urandom_range(0, span - 64);
    else start = $urandom_range(0, span);
    n = $urandom_range(2, 6);
    send_op(mk_op(FUNC_SEEK, $urandom(), random_count(), 1'($urandom_range(0, 1)),
                  14'(start)));
    for (int i = 0; i < n; i++) begin
      cnt_list[i] = random_count();
      sgn_list[i] = 1'($urandom_range(0, 1));
      send_op(mk_op(FUNC_WRITE, random_value(), cnt_list[i], sgn_list[i], 14'($urandom())));
    end
    send_op(mk_op(FUNC_SEEK, $urandom(), random_count(), 1'($urandom_range(0, 1)),
                  14'(start)));
    for (int i = 0; i < n; i++) begin
      send_op(mk_op(FUNC_READ, $urandom(), cnt_list[i], sgn_list[i], 14'($urandom())));
    end
  endtask

  // Random stream of round trips and noise until the item count is reached.
  task automatic run_random_items(input int unsigned count);
    int unsigned target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) run_round_trip();
      else send_op(random_noise_op());
    end
  endtask

  // Both limits are zero after reset: every field fails, and so does a seek past zero.
  task automatic test_reset_limits();
    send_op(mk_op(FUNC_WRITE, 32'hA5, 6'd8, 1'b0, 14'd0));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd1));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd0));
    send_op(mk_op(FUNC_RESTART, 32'd0, 6'd1, 1'b0, 14'd0));
    drain_stream();
  endtask

  // Field width and value extremes, then the top of the store.
  task automatic test_field_extremes();
    set_limits(11'd2047, 11'd2047);
    send_op(mk_op(FUNC_WRITE, 32'hFFFF_FFFF, 6'd0, 1'b0, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'h8000_0000, 6'd32, 1'b1, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'hFFFF_FFFB, 6'd1, 1'b1, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'h1234_5678, 6'd63, 1'b0, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'h0000_0007, 6'd5, 1'b1, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'h8000_0000, 6'd40, 1'b1, 14'd0));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd0, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd32, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd32, 1'b1, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd1, 1'b1, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd63, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd5, 1'b1, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd40, 1'b1, 14'd0));
    // The cursor may sit exactly at the end of the store, but no field fits.
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd8192));
    send_op(mk_op(FUNC_WRITE, 32'd1, 6'd1, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd1, 1'b0, 14'd0));
    // The error stays set while later transactions still run.
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'h3FFF));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd8191));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd1, 1'b1, 14'd0));
    send_op(mk_op(FUNC_RESTART, 32'd0, 6'd1, 1'b0, 14'd0));
    drain_stream();
  endtask

  // Lowering the limits below the cursor makes every nonzero field fail.
  task automatic test_shrunken_limit();
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd4000));
    send_op(mk_op(FUNC_WRITE, 32'hBEEF, 6'd16, 1'b0, 14'd0));
    drain_stream();
    set_limits(11'd4, 11'd3);
    send_op(mk_op(FUNC_WRITE, 32'h5A, 6'd8, 1'b0, 14'd0));
    send_op(mk_op(FUNC_READ, 32'd0, 6'd8, 1'b0, 14'd0));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd33));
    send_op(mk_op(FUNC_SEEK, 32'd0, 6'd1, 1'b0, 14'd32));
    send_op(mk_op(FUNC_WRITE, 32'd1, 6'd1, 1'b0, 14'd0));
    send_op(mk_op(FUNC_RESTART, 32'd0, 6'd1, 1'b0, 14'd0));
    send_op(mk_op(FUNC_WRITE, 32'h00C0_FFEE, 6'd24, 1'b0, 14'd0));
    drain_stream();
  endtask

  // The receiver holds off while the sender keeps offering, so the block
  // fills up and stalls its input.
  task automatic test_backpressure();
    set_limits(11'd1024, 11'd1024);
    sender_idle = 1'b0;
    hold_cycles = 200;
    run_random_items(30);
    sender_idle = 1'b1;
    drain_stream();
  endtask

  // Random round trips over several limit settings, extremes included.
  task automatic test_random_phases();
    logic [LIM_W-1:0] rd_set [7] = '{11'd2047, 11'd1024, 11'd0, 11'd5, 11'd8, 11'd300, 11'd0};
    logic [LIM_W-1:0] wr_set [7] = '{11'd2047, 11'd1024, 11'd0, 11'd8, 11'd5, 11'd120, 11'd0};
    int unsigned      count  [7] = '{120, 120, 30, 100, 100, 120, 100};
    rd_set[6] = 11'($urandom_range(0, 2047));
    wr_set[6] = 11'($urandom_range(0, 2047));
    for (int p = 0; p < 7; p++) begin
      set_limits(rd_set[p], wr_set[p]);
      run_random_items(count[p] / 2);
      // Sender pauses until everything outstanding has come back.
      drain_stream();
      run_random_items(count[p] - count[p] / 2);
      drain_stream();
    end
  endtask

  // Last stretch: neither side idles.
  task automatic test_steady_stream();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    set_limits(11'd64, 11'd64);
    run_random_items(100);
    drain_stream();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_WRITE;
    value_i         <= '0;
    bit_count_i     <= '0;
    signed_mode_i   <= 1'b0;
    seek_position_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_READ_LIMIT;
    cfg_data_i      <= '0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_cursor = 0;
    shadow_err    = 1'b0;
    shadow_rd_lim = '0;
    shadow_wr_lim = '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_cycles   = 0;
    stall_left    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_limits();
    test_field_extremes();
    test_shrunken_limit();
    test_backpressure();
    test_random_phases();
    test_steady_stream();

    // Give a stray extra result time to show up.
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items (%0d writes, %0d reads, %0d seeks, %0d restarts), %0d checked.",
             items_sent, func_count[FUNC_WRITE], func_count[FUNC_READ],
             func_count[FUNC_SEEK], func_count[FUNC_RESTART], results_seen);
    $display("%0d limit settings, %0d range errors, %0d seeks ignored, %0d mismatches.",
             limit_settings, range_fails, seeks_ignored, mismatches);
    if (mismatches == 0 && stream_results_q.size() == 0) begin
      $display("PASS bit_stream_packer_unpacker");
    end else begin
      $display("FAIL bit_stream_packer_unpacker");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bspu_pkg.sv
rtl/bspu_ram.sv
rtl/bspu_fifo.sv
rtl/bspu_front.sv
rtl/bspu_back.sv
rtl/bit_stream_packer_unpacker.sv
verif/bit_stream_packer_unpacker_tb.sv
